// ===== rtl/block_coefficient_multiply_top_macros.svh =====
// Assertion macros for the block coefficient multiply checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BLOCK_COEFFICIENT_MULTIPLY_TOP_MACROS_SVH
`define BLOCK_COEFFICIENT_MULTIPLY_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in block coefficient multiply");

// Next-cycle implication, disabled while reset is asserted.
`define BCM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in block coefficient multiply");

`endif

// ===== rtl/bcm_pkg.sv =====
// Shared constants, codes and types for the block coefficient multiply.
// No dependencies.
package bcm_pkg;

    localparam int BLOCK_N   = 8;
    localparam int STORE_DIM = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = STORE_DIM * STORE_DIM;
    localparam int SAMPLE_W  = 16;
    localparam int COEFF_W   = 8;
    localparam int PROD_W    = SAMPLE_W + COEFF_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int SUM_W     = 26;
    localparam int OP_W      = 2;
    localparam int CFG_W     = STORE_DIM * COEFF_W;
    localparam int CFG_IDX_W = 4;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_N - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(STORE_DIM);

    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(33554431);
    localparam logic signed [ACC_W-1:0] SUM_MIN = -ACC_W'(33554432);

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_LEFT  = 2'd1;
    localparam logic [OP_W-1:0] OP_RIGHT = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

// ===== rtl/bcm_sample_mem.sv =====
// Sample store: 64 entries of 16 bits with per-entry valid bits cleared at reset.
// Depends on bcm_pkg.
module bcm_sample_mem (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [bcm_pkg::ADDR_W-1:0]           wr_addr,
    input  logic signed [bcm_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic [bcm_pkg::ADDR_W-1:0]           rd_addr,
    output logic signed [bcm_pkg::SAMPLE_W-1:0]  rd_data
);
    import bcm_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;
    logic                       rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/bcm_mac.sv =====
// Shared multiply-accumulate unit: one registered product per cycle, then a saturated sum.
// Depends on bcm_pkg.
module bcm_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bcm_pkg::mac_ctl_t                    ctl,
    input  logic signed [bcm_pkg::SAMPLE_W-1:0]  sample_val,
    input  logic signed [bcm_pkg::COEFF_W-1:0]   coeff_val,
    output logic signed [bcm_pkg::SUM_W-1:0]     sum,
    output logic                                 done
);
    import bcm_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 pctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;

    always_comb
    begin
        acc_next = (pctl_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= sample_val * coeff_val;
        if (pctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pctl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pctl_reg <= ctl;
            done_reg <= pctl_reg.valid && pctl_reg.last;
        end
    end

    always_comb
    begin
        if (acc_reg > SUM_MAX)
        begin
            sum = SUM_MAX[SUM_W-1:0];
        end
        else if (acc_reg < SUM_MIN)
        begin
            sum = SUM_MIN[SUM_W-1:0];
        end
        else
        begin
            sum = acc_reg[SUM_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== rtl/block_coefficient_multiply_top.sv =====
// Block coefficient multiply: a load item writes one sample and gives no result.
// A compute item emits BLOCK_N*BLOCK_N results, each the sum of BLOCK_N products;
// the single multiply-accumulate unit takes one product per cycle while the block
// issues, and issue waits while a result drains or is held by a stalled output.
// The block takes no new item until the last result has been loaded for output.
// Reset is asynchronous, active low; it clears the sample store and coefficients.
module block_coefficient_multiply_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [bcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bcm_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [bcm_pkg::OP_W-1:0]             op,
    input  logic [bcm_pkg::IDX_W-1:0]            row,
    input  logic [bcm_pkg::IDX_W-1:0]            col,
    input  logic signed [bcm_pkg::SAMPLE_W-1:0]  sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [bcm_pkg::IDX_W-1:0]            out_row,
    output logic [bcm_pkg::IDX_W-1:0]            out_col,
    output logic signed [bcm_pkg::SUM_W-1:0]     sum,
    output logic                                 last
);
    import bcm_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           i_reg, i_next;
    logic [IDX_W-1:0]           j_reg, j_next;
    logic [IDX_W-1:0]           k_reg, k_next;
    logic                       left_reg, left_next;
    logic [CFG_W-1:0]           coeff_rows_reg [STORE_DIM];
    logic signed [COEFF_W-1:0]  coeff_q_reg;
    mac_ctl_t                   issue_ctl_reg, issue_ctl_next;
    logic                       out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]           out_row_reg;
    logic [IDX_W-1:0]           out_col_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic                       last_reg;

    logic                       accept_in;
    logic                       emit;
    logic                       mem_wr_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [IDX_W-1:0]           coeff_row_sel;
    logic signed [SAMPLE_W-1:0] mem_rd_data;
    logic signed [SUM_W-1:0]    mac_sum;
    logic                       mac_done;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign mem_wr_en = accept_in && (op == OP_LOAD);
    assign emit      = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign rd_addr       = left_reg ? {k_reg, j_reg} : {i_reg, k_reg};
    assign coeff_row_sel = left_reg ? i_reg : j_reg;

    bcm_sample_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .wr_addr ({row, col}),
        .wr_data (sample),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    bcm_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (issue_ctl_reg),
        .sample_val (mem_rd_data),
        .coeff_val  (coeff_q_reg),
        .sum        (mac_sum),
        .done       (mac_done)
    );

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        left_next      = left_reg;
        issue_ctl_next = '0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_in && (op == OP_LEFT || op == OP_RIGHT))
                begin
                    left_next  = (op == OP_LEFT);
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                issue_ctl_next.valid = 1'b1;
                issue_ctl_next.first = (k_reg == '0);
                issue_ctl_next.last  = (k_reg == IDX_LAST);
                if (k_reg == IDX_LAST)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_ISSUE;
                    if (j_reg == IDX_LAST)
                    begin
                        j_next = '0;
                        if (i_reg == IDX_LAST)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            left_reg      <= 1'b0;
            issue_ctl_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < STORE_DIM; r++)
            begin
                coeff_rows_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            left_reg      <= left_next;
            issue_ctl_reg <= issue_ctl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en && (cfg_index < CFG_ROWS))
            begin
                coeff_rows_reg[cfg_index[IDX_W-1:0]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        coeff_q_reg <= coeff_rows_reg[coeff_row_sel][k_reg * COEFF_W +: COEFF_W];
        if (emit)
        begin
            out_row_reg <= i_reg;
            out_col_reg <= j_reg;
            sum_reg     <= mac_sum;
            last_reg    <= (i_reg == IDX_LAST) && (j_reg == IDX_LAST);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign sum       = sum_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/bcm_checker.sv =====
// Port-level checker for the block coefficient multiply, bound to the top level.
// Depends on bcm_pkg and block_coefficient_multiply_top_macros.svh.
`include "block_coefficient_multiply_top_macros.svh"

module bcm_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic [bcm_pkg::OP_W-1:0]             op,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic [bcm_pkg::IDX_W-1:0]            out_row,
    input  logic [bcm_pkg::IDX_W-1:0]            out_col,
    input  logic signed [bcm_pkg::SUM_W-1:0]     sum,
    input  logic                                 last
);
    import bcm_pkg::*;

    `BCM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sum) && $stable(out_row) && $stable(out_col) && $stable(last))
    `BCM_ASSERT_NXT(a_busy_after_compute, in_valid && !in_stall && (op == OP_LEFT || op == OP_RIGHT), in_stall)
    `BCM_ASSERT_IMP(a_last_position, out_valid && last, out_row == IDX_LAST && out_col == IDX_LAST)
    `BCM_ASSERT_IMP(a_busy_mid_block, out_valid && !last, in_stall)

endmodule

bind block_coefficient_multiply_top bcm_checker u_bcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .sum       (sum),
    .last      (last)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for block_coefficient_multiply_top: loads and computes go in,
// and every result element is checked against a local model of the coefficient multiply.
// Depends on bcm_pkg and the RTL top level only.
module testbench;
    import bcm_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 48;

    typedef struct {
        logic [OP_W-1:0]            op;
        logic [IDX_W-1:0]           row;
        logic [IDX_W-1:0]           col;
        logic signed [SAMPLE_W-1:0] sample;
        bit                         wait_drain;
    } block_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        r;
        logic [IDX_W-1:0]        c;
        logic signed [SUM_W-1:0] s;
        logic                    l;
    } block_sum_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [OP_W-1:0]            op = OP_LOAD;
    logic [IDX_W-1:0]           row = '0;
    logic [IDX_W-1:0]           col = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [IDX_W-1:0]           out_row;
    logic [IDX_W-1:0]           out_col;
    logic signed [SUM_W-1:0]    sum;
    logic                       last;

    block_coefficient_multiply_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .row       (row),
        .col       (col),
        .sample    (sample),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .sum       (sum),
        .last      (last)
    );

    block_item_t item_fifo[$];
    block_sum_t  sum_fifo[$];

    logic [CFG_W-1:0]           coeff_model [STORE_DIM];
    logic signed [SAMPLE_W-1:0] sample_model [DEPTH];

    int  items_queued = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  computes_seen = 0;
    int  noops_seen = 0;
    int  settings_used = 0;
    int  errors = 0;
    int  idle_run = 0;
    int  send_idle_pct = 11;
    int  recv_idle_pct = 50;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  item_taken = 1'b0;
    bit  progress;
    block_item_t drv_item;
    block_sum_t  want;
    block_sum_t  got;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint coeff_of(int r, int c);
        logic signed [COEFF_W-1:0] b;
        b = coeff_model[r][COEFF_W*c +: COEFF_W];
        return longint'(b);
    endfunction

    function automatic longint sample_of(int r, int c);
        return longint'(sample_model[r*STORE_DIM + c]);
    endfunction

    task automatic predict_block(logic [OP_W-1:0] mode);
        longint     acc;
        block_sum_t res;
        for (int i = 0; i < BLOCK_N; i++)
        begin
            for (int j = 0; j < BLOCK_N; j++)
            begin
                acc = 0;
                for (int k = 0; k < BLOCK_N; k++)
                begin
                    if (mode == OP_LEFT)
                        acc += coeff_of(i, k) * sample_of(k, j);
                    else
                        acc += sample_of(i, k) * coeff_of(j, k);
                end
                if (acc > 64'sd33554431)
                    acc = 64'sd33554431;
                if (acc < -64'sd33554432)
                    acc = -64'sd33554432;
                res.r = IDX_W'(i);
                res.c = IDX_W'(j);
                res.s = SUM_W'(acc);
                res.l = (i == BLOCK_N - 1) && (j == BLOCK_N - 1);
                sum_fifo.push_back(res);
            end
        end
    endtask

    task automatic apply_item(logic [OP_W-1:0] o, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                              logic signed [SAMPLE_W-1:0] s);
        if (o == OP_LOAD)
            sample_model[{r, c}] = s;
        else if (o == OP_LEFT || o == OP_RIGHT)
        begin
            computes_seen++;
            predict_block(o);
        end
        else
            noops_seen++;
    endtask

    // Monitor: outputs are checked before the accepted input is predicted.
    always @(posedge clk)
    begin
        item_taken = 1'b0;
        if (rst_n)
        begin
            progress = cfg_wr_en;
            if (out_valid && !out_stall)
            begin
                progress = 1'b1;
                results_seen++;
                got = '{r: out_row, c: out_col, s: sum, l: last};
                if (sum_fifo.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: row %0d col %0d sum %0d last %0b",
                                 got.r, got.c, got.s, got.l);
                end
                else
                begin
                    want = sum_fifo.pop_front();
                    if (got != want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected row %0d col %0d sum %0d last %0b,",
                                     want.r, want.c, want.s, want.l,
                                     " got row %0d col %0d sum %0d last %0b",
                                     got.r, got.c, got.s, got.l);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                progress = 1'b1;
                item_taken = 1'b1;
                items_accepted++;
                apply_item(op, row, col, sample);
            end
            idle_run = progress ? 0 : idle_run + 1;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("timeout: no item or result moved for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || item_taken)
        begin
            if (item_fifo.size() != 0 && !(item_fifo[0].wait_drain && sum_fifo.size() != 0)
                && $urandom_range(99) >= send_idle_pct)
            begin
                drv_item = item_fifo.pop_front();
                in_valid <= 1'b1;
                op       <= drv_item.op;
                row      <= drv_item.row;
                col      <= drv_item.col;
                sample   <= drv_item.sample;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: one long hold-off while an item waits at the input, random stalls otherwise.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && results_seen >= HOLD_AFTER && in_valid && in_stall)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic push_item(logic [OP_W-1:0] o, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                             logic signed [SAMPLE_W-1:0] s, bit drain);
        block_item_t it;
        it = '{op: o, row: r, col: c, sample: s, wait_drain: drain};
        item_fifo.push_back(it);
        items_queued++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return -16'sd32768;
        if (pick == 1)
            return 16'sd32767;
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] rand_coeff_row();
        logic [CFG_W-1:0] v;
        logic [7:0]       extremes [4];
        extremes = '{8'h80, 8'h7F, 8'h00, 8'hFF};
        for (int b = 0; b < STORE_DIM; b++)
        begin
            if ($urandom_range(3) == 0)
                v[8*b +: 8] = extremes[$urandom_range(3)];
            else
                v[8*b +: 8] = 8'($urandom);
        end
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] coeff_pattern(int setting, int r);
        case (setting)
            0: return {8{8'h7F}};
            1: return {8{8'hFF}};
            3: return '0;
            4: return (r % 2 == 0) ? rand_coeff_row() : '0;
            6: return {8{8'h80}};
            default: return rand_coeff_row();
        endcase
    endfunction

    task automatic program_coeffs(int setting);
        logic [CFG_W-1:0] v;
        for (int r = 0; r < STORE_DIM; r++)
        begin
            v = coeff_pattern(setting, r);
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_data  <= v;
            coeff_model[r] = v;
            @(negedge clk);
        end
        // Indexes past the last row must leave the coefficients untouched.
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ROWS + CFG_IDX_W'($urandom_range(STORE_DIM - 1));
        cfg_data  <= {$urandom, $urandom};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_quiet();
        while (items_accepted != items_queued || sum_fifo.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic add_random_items(int count);
        int n;
        int burst;
        bit drain_set;
        n = 0;
        drain_set = 1'b0;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(2))
                    0: push_item(OP_NONE, 3'($urandom), 3'($urandom), rand_sample(), 1'b0);
                    1: push_item($urandom_range(1) ? OP_LEFT : OP_RIGHT, 3'($urandom),
                                 3'($urandom), rand_sample(), 1'b0);
                    default: push_item(OP_LOAD, 3'($urandom), 3'($urandom), rand_sample(),
                                       1'b0);
                endcase
                n++;
            end
            else
            begin
                burst = $urandom_range(1, 10);
                for (int b = 0; b < burst; b++)
                    push_item(OP_LOAD, 3'($urandom), 3'($urandom), rand_sample(), 1'b0);
                push_item($urandom_range(1) ? OP_LEFT : OP_RIGHT, 3'($urandom), 3'($urandom),
                          rand_sample(), !drain_set && n >= 20);
                if (n >= 20)
                    drain_set = 1'b1;
                n += burst + 1;
            end
        end
    endtask

    initial
    begin
        for (int r = 0; r < STORE_DIM; r++)
            coeff_model[r] = '0;
        for (int a = 0; a < DEPTH; a++)
            sample_model[a] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: saturation on both multiply modes, ignored fields, the unused op.
        program_coeffs(6);
        for (int k = 0; k < STORE_DIM; k++)
            push_item(OP_LOAD, 3'(k), 3'd0, -16'sd32768, 1'b0);
        push_item(OP_LEFT, 3'd7, 3'd7, -16'sd1, 1'b0);
        for (int j = 1; j < STORE_DIM; j++)
            push_item(OP_LOAD, 3'd0, 3'(j), -16'sd32768, 1'b0);
        push_item(OP_RIGHT, 3'd0, 3'd0, 16'sd32767, 1'b1);
        push_item(OP_NONE, 3'd5, 3'd2, 16'sd1234, 1'b0);
        push_item(OP_LOAD, 3'd7, 3'd7, 16'sd32767, 1'b0);
        push_item(OP_LOAD, 3'd3, 3'd5, 16'sd21845, 1'b0);
        push_item(OP_LOAD, 3'd5, 3'd3, -16'sd21846, 1'b0);
        push_item(OP_LEFT, 3'd0, 3'd7, 16'sd0, 1'b0);
        push_item(OP_NONE, 3'd7, 3'd7, -16'sd32768, 1'b0);
        push_item(OP_RIGHT, 3'd7, 3'd0, -16'sd32768, 1'b0);
        wait_quiet();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 11;
                    recv_idle_pct = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    recv_idle_pct = 11;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            program_coeffs(ph);
            add_random_items(PHASE_ITEMS);
            wait_quiet();
        end
        repeat (50) @(negedge clk);

        $display("Run covered %0d items (%0d computes, %0d unused-op items) and %0d results",
                 items_accepted, computes_seen, noops_seen, results_seen);
        $display("across %0d coefficient settings, with %0d mismatches.",
                 settings_used, errors);
        if (errors == 0 && sum_fifo.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bcm_pkg.sv
rtl/bcm_sample_mem.sv
rtl/bcm_mac.sv
rtl/block_coefficient_multiply_top.sv
rtl/bcm_checker.sv
verif/testbench.sv
